@@ rtl/gimbal_status_frame_parser_top_macros.svh @@
// Assertion helpers for the frame parser; clocked on clk, off in reset.
`ifndef GIMBAL_STATUS_FRAME_PARSER_TOP_MACROS_SVH
`define GIMBAL_STATUS_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication
`define GSFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GSFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gsfp_pkg.sv @@
package gsfp_pkg;

    // Frame layout
    localparam logic [7:0] SYNC_A = 8'hB5;
    localparam logic [7:0] SYNC_B = 8'h9A;
    localparam int OFF_SYNC_A   = 0;
    localparam int OFF_SYNC_B   = 1;
    localparam int OFF_CMD      = 5;
    localparam int OFF_CAM_ROLL = 12;
    localparam int OFF_CAM_PIT  = 14;
    localparam int OFF_CAM_YAW  = 16;
    localparam int OFF_MOT_PIT  = 18;
    localparam int OFF_MOT_ROLL = 20;
    localparam int OFF_MOT_YAW  = 22;
    localparam int OFF_CRC_HI   = 24;
    localparam int OFF_CRC_LO   = 25;

    // Command that marks manual mode confirmed
    localparam logic [4:0] CMD_MANUAL    = 5'd4;
    localparam logic [2:0] STAT_MANUAL_OK = 3'd1;

    // CRC-16 poly 0x1021, one nibble at a time
    localparam logic [15:0] NIB_TAB [16] = '{
        16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50A5, 16'h60C6, 16'h70E7,
        16'h8108, 16'h9129, 16'hA14A, 16'hB16B, 16'hC18C, 16'hD1AD, 16'hE1CE, 16'hF1EF
    };

    // Window write/shift/clear controls
    typedef struct packed {
        logic wr_en;
        logic shift_en;
        logic clr_en;
    } win_ctrl_t;

    function automatic logic [15:0] crc_nib_step(input logic [15:0] crc, input logic [3:0] nib);
        logic [3:0] idx;
        idx = crc[15:12] ^ nib;
        return {crc[11:0], 4'h0} ^ NIB_TAB[idx];
    endfunction

endpackage

@@ rtl/gsfp_window.sv @@
module gsfp_window #(
    parameter int FRAME_BYTES = 26,
    localparam int IW = $clog2(FRAME_BYTES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gsfp_pkg::win_ctrl_t ctrl,
    input  logic [IW-1:0]       wr_idx,
    input  logic [7:0]          wr_data,
    input  logic [IW-1:0]       rd_idx,
    output logic [7:0]          rd_data,
    output logic [7:0]          win_bytes [FRAME_BYTES]
);
    import gsfp_pkg::*;

    logic [7:0] win_reg  [FRAME_BYTES];
    logic [7:0] win_next [FRAME_BYTES];

    // Clear, slide down by one, or store one byte
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (ctrl.clr_en)
            begin
                win_next[i] = 8'h00;
            end
            else if (ctrl.shift_en)
            begin
                win_next[i] = (i == FRAME_BYTES - 1) ? 8'h00 : win_reg[(i + 1) % FRAME_BYTES];
            end
            else if (ctrl.wr_en && (wr_idx == IW'(i)))
            begin
                win_next[i] = wr_data;
            end
            else
            begin
                win_next[i] = win_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                win_reg[i] <= 8'h00;
            end
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    // Single indexed read for the CRC walk
    assign rd_data   = win_reg[rd_idx];
    assign win_bytes = win_reg;

endmodule

@@ rtl/gsfp_crc.sv @@
module gsfp_crc #(
    parameter int FRAME_BYTES = 26,
    localparam int IW      = $clog2(FRAME_BYTES),
    localparam int NIBBLES = 2 * (FRAME_BYTES - 2),
    localparam int CW      = $clog2(NIBBLES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [7:0]    data_byte,
    output logic [IW-1:0] byte_idx,
    output logic          done,
    output logic [15:0]   crc
);
    import gsfp_pkg::*;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [15:0]   crc_reg, crc_next;
    logic [3:0]    nib;

    // High nibble first, then low nibble of the same byte
    assign nib      = cnt_reg[0] ? data_byte[3:0] : data_byte[7:4];
    assign byte_idx = IW'(cnt_reg >> 1);

    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        crc_next  = crc_reg;
        if (start)
        begin
            cnt_next = '0;
            run_next = 1'b1;
            crc_next = 16'h0000;
        end
        else if (run_reg)
        begin
            crc_next = crc_nib_step(crc_reg, nib);
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(NIBBLES - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            crc_reg  <= 16'h0000;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
            crc_reg  <= crc_next;
        end
    end

    assign done = done_reg;
    assign crc  = crc_reg;

endmodule

@@ rtl/gimbal_status_frame_parser_top.sv @@
// Bytes that do not fill the window are taken one per cycle.
// The byte that fills the window starts a CRC walk (one nibble per cycle
// through the CRC nibble step), then done is registered and a check state follows:
// the next byte is taken once the check is through, later while a result waits.
// A passing frame is loaded into the output registers from the check state.
// Reset (rst_n, asynchronous, active low) empties the window and clears all flags.
module gimbal_status_frame_parser_top #(
    parameter int FRAME_BYTES = 26
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] cam_roll,
    output logic signed [15:0] cam_pitch,
    output logic signed [15:0] cam_yaw,
    output logic signed [15:0] motor_pitch,
    output logic signed [15:0] motor_roll,
    output logic signed [15:0] motor_yaw,
    output logic [4:0]         command_value,
    output logic [2:0]         command_status,
    output logic               manual_confirmed,
    output logic               first_frame
);
    import gsfp_pkg::*;

    localparam int IW = $clog2(FRAME_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CRC,
        S_CHECK
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] fill_reg, fill_next;
    logic          manual_reg, manual_next;
    logic          frame_seen_reg, frame_seen_next;
    logic          out_valid_reg, out_valid_next;
    logic [15:0]   angle_reg [6];
    logic [15:0]   angle_next [6];
    logic [4:0]    cval_reg, cval_next;
    logic [2:0]    cstat_reg, cstat_next;
    logic          man_out_reg, man_out_next;
    logic          first_reg, first_next;

    win_ctrl_t     win_ctrl;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] crc_idx;
    logic [7:0]    crc_byte;
    logic [7:0]    win [FRAME_BYTES];
    logic          crc_start;
    logic          crc_done;
    logic [15:0]   crc_val;
    logic          in_acc;
    logic          full;
    logic          frame_ok;
    logic [4:0]    cval;
    logic [2:0]    cstat;

    gsfp_window #(.FRAME_BYTES(FRAME_BYTES)) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (win_ctrl),
        .wr_idx    (wr_idx),
        .wr_data   (rx_byte),
        .rd_idx    (crc_idx),
        .rd_data   (crc_byte),
        .win_bytes (win)
    );

    gsfp_crc #(.FRAME_BYTES(FRAME_BYTES)) u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (crc_start),
        .data_byte (crc_byte),
        .byte_idx  (crc_idx),
        .done      (crc_done),
        .crc       (crc_val)
    );

    // Input handshake: take bytes only while idle
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign full      = (fill_reg == IW'(FRAME_BYTES - 1));
    assign wr_idx    = fill_reg;
    assign crc_start = in_acc && full;

    // Header and CRC check, command split
    assign frame_ok = (win[OFF_SYNC_A] == SYNC_A) && (win[OFF_SYNC_B] == SYNC_B) &&
                      (win[OFF_CRC_HI] == crc_val[15:8]) && (win[OFF_CRC_LO] == crc_val[7:0]);
    assign cval  = win[OFF_CMD][7:3];
    assign cstat = win[OFF_CMD][2:0];

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        manual_next     = manual_reg;
        frame_seen_next = frame_seen_reg;
        out_valid_next  = out_valid_reg && out_stall;
        angle_next      = angle_reg;
        cval_next       = cval_reg;
        cstat_next      = cstat_reg;
        man_out_next    = man_out_reg;
        first_next      = first_reg;
        win_ctrl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    win_ctrl.wr_en = 1'b1;
                    if (full)
                    begin
                        state_next = S_CRC;
                    end
                    else
                    begin
                        fill_next = fill_reg + IW'(1);
                    end
                end
            end
            S_CRC:
            begin
                if (crc_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!frame_ok)
                begin
                    // drop the oldest byte, keep 25
                    win_ctrl.shift_en = 1'b1;
                    fill_next         = IW'(FRAME_BYTES - 1);
                    state_next        = S_IDLE;
                end
                else if (!(out_valid_reg && out_stall))
                begin
                    // load result, empty the window
                    manual_next     = manual_reg ||
                                      ((cval == CMD_MANUAL) && (cstat == STAT_MANUAL_OK));
                    frame_seen_next = 1'b1;
                    out_valid_next  = 1'b1;
                    angle_next[0]   = {win[OFF_CAM_ROLL + 1], win[OFF_CAM_ROLL]};
                    angle_next[1]   = {win[OFF_CAM_PIT + 1],  win[OFF_CAM_PIT]};
                    angle_next[2]   = {win[OFF_CAM_YAW + 1],  win[OFF_CAM_YAW]};
                    angle_next[3]   = {win[OFF_MOT_PIT + 1],  win[OFF_MOT_PIT]};
                    angle_next[4]   = {win[OFF_MOT_ROLL + 1], win[OFF_MOT_ROLL]};
                    angle_next[5]   = {win[OFF_MOT_YAW + 1],  win[OFF_MOT_YAW]};
                    cval_next       = cval;
                    cstat_next      = cstat;
                    man_out_next    = manual_next;
                    first_next      = !frame_seen_reg;
                    win_ctrl.clr_en = 1'b1;
                    fill_next       = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            manual_reg     <= 1'b0;
            frame_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                angle_reg[i] <= 16'h0000;
            end
            cval_reg       <= '0;
            cstat_reg      <= '0;
            man_out_reg    <= 1'b0;
            first_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            manual_reg     <= manual_next;
            frame_seen_reg <= frame_seen_next;
            out_valid_reg  <= out_valid_next;
            angle_reg      <= angle_next;
            cval_reg       <= cval_next;
            cstat_reg      <= cstat_next;
            man_out_reg    <= man_out_next;
            first_reg      <= first_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign cam_roll         = angle_reg[0];
    assign cam_pitch        = angle_reg[1];
    assign cam_yaw          = angle_reg[2];
    assign motor_pitch      = angle_reg[3];
    assign motor_roll       = angle_reg[4];
    assign motor_yaw        = angle_reg[5];
    assign command_value    = cval_reg;
    assign command_status   = cstat_reg;
    assign manual_confirmed = man_out_reg;
    assign first_frame      = first_reg;

`include "gimbal_status_frame_parser_top_macros.svh"

    `GSFP_ASSERT_NEXT(a_full_starts_crc, crc_start, state_reg == S_CRC, "filling byte did not start CRC")
    `GSFP_ASSERT_NOW(a_done_in_crc, crc_done, state_reg == S_CRC, "CRC done outside CRC state")
    `GSFP_ASSERT_NOW(a_fill_range, 1'b1, fill_reg <= IW'(FRAME_BYTES - 1), "window fill out of range")
    `GSFP_ASSERT_NOW(a_first_seen, out_valid_reg && first_reg, frame_seen_reg, "first frame flag without frame")

endmodule
